### sv/c8ex_pkg.sv
// Types and opcode constants shared by the CHIP-8 execute unit.
package c8ex_pkg;

    // Program counter after reset
    localparam logic [11:0] PC_RESET = 12'h200;

    // Instruction step, added to the PC per instruction and per taken skip
    localparam logic [11:0] PC_STEP = 12'd2;

    // Register number of the flag register VF
    localparam logic [3:0] FLAG_IDX = 4'hF;

    // Major opcodes (bits 15:12)
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SE_I  = 4'h3;
    localparam logic [3:0] OP_SNE_I = 4'h4;
    localparam logic [3:0] OP_SE_R  = 4'h5;
    localparam logic [3:0] OP_LD_I  = 4'h6;
    localparam logic [3:0] OP_ADD_I = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNE_R = 4'h9;
    localparam logic [3:0] OP_LD_IX = 4'hA;
    localparam logic [3:0] OP_JP_V0 = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    // 8XYN sub-operations
    localparam logic [3:0] ALU_LD  = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // EXNN key skips
    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    // FXNN sub-operations
    localparam logic [7:0] FX_LD_DT  = 8'h07;
    localparam logic [7:0] FX_WAITK  = 8'h0A;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_STORE  = 8'h55;
    localparam logic [7:0] FX_LOAD   = 8'h65;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNIMPL  = 2'd1,
        ST_UNKNOWN = 2'd2
    } c8ex_status_t;

    typedef struct packed {
        logic [15:0] instruction;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
    } c8ex_in_t;

    typedef struct packed {
        logic [11:0]  next_pc;
        logic [15:0]  index_value;
        logic [7:0]   delay_value;
        logic [7:0]   sound_value;
        c8ex_status_t status;
    } c8ex_out_t;

    // Register file write-back from the execute logic
    typedef struct packed {
        logic       gpr_we;
        logic [3:0] gpr_addr;
        logic [7:0] gpr_data;
        logic       flag_we;
        logic       flag;
    } c8ex_wb_t;

endpackage

### sv/chip8_instruction_execute_unit.sv
// CHIP-8 instruction execute unit: one fetched instruction in, one status item out.
// Operands are captured into the input stage at accept; the item then executes into the
// result register once that register is empty or being drained.
// Throughput: one instruction per clock while out_stall is low; execute runs in the cycle the result register frees.
// Operands Vx/Vy are read into the input stage with forwarding from the executing item.
// Reset: PC = 0x200, V0..VF, I and both timers read zero, both stages empty.
// cfg_we loads the PC directly; write only while the unit is idle.
module chip8_instruction_execute_unit
    import c8ex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  c8ex_in_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output c8ex_out_t   out_item,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data
);

    // input stage: instruction plus captured operands
    logic         in_valid_reg;
    logic         in_valid_next;
    c8ex_in_t     in_reg;

    // result stage
    logic         out_valid_reg;
    logic         out_valid_next;
    c8ex_out_t    out_reg;

    // architectural state outside the register file
    logic [11:0]  pc_reg;
    logic [15:0]  index_reg;
    logic [7:0]   delay_reg;
    logic [7:0]   sound_reg;

    logic         in_take;
    logic         exec_go;

    logic [7:0]   vx;
    logic [7:0]   vy;
    logic [7:0]   v0;
    logic [11:0]  pc_new;
    logic [15:0]  index_new;
    logic [7:0]   delay_new;
    logic [7:0]   sound_new;
    c8ex_status_t status;
    c8ex_wb_t     wb;

    // The held item executes whenever the result register is empty or being drained.
    assign exec_go       = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall      = in_valid_reg && !exec_go;
    assign in_take       = in_valid && !in_stall;
    assign in_valid_next = in_take || (in_valid_reg && !exec_go);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    c8ex_gpr u_gpr (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (in_take),
        .rd_x  (in_item.instruction[11:8]),
        .rd_y  (in_item.instruction[7:4]),
        .wb_en (exec_go),
        .wb    (wb),
        .vx    (vx),
        .vy    (vy),
        .v0    (v0)
    );

    c8ex_exec u_exec (
        .item      (in_reg),
        .vx        (vx),
        .vy        (vy),
        .v0        (v0),
        .pc        (pc_reg),
        .index_cur (index_reg),
        .delay_cur (delay_reg),
        .sound_cur (sound_reg),
        .pc_new    (pc_new),
        .index_new (index_new),
        .delay_new (delay_new),
        .sound_new (sound_new),
        .status    (status),
        .wb        (wb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= PC_RESET;
            index_reg     <= '0;
            delay_reg     <= '0;
            sound_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                pc_reg <= cfg_data;
            else if (exec_go)
                pc_reg <= pc_new;
            if (exec_go)
            begin
                index_reg <= index_new;
                delay_reg <= delay_new;
                sound_reg <= sound_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_reg <= in_item;
        if (exec_go)
        begin
            out_reg.next_pc     <= pc_new;
            out_reg.index_value <= index_new;
            out_reg.delay_value <= delay_new;
            out_reg.sound_value <= sound_new;
            out_reg.status      <= status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // input side only backs up when a finished result is waiting on a stalled consumer
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // an executed item always shows up on the output next cycle
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid)
        else $error("executed item not presented");

    // without a configuration write, PC mirrors an executed item's next_pc
    a_pc_result: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && !cfg_we) |=> (pc_reg == out_item.next_pc))
        else $error("PC and result next_pc disagree");

    // a configuration write loads the PC
    a_cfg_pc: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (pc_reg == $past(cfg_data)))
        else $error("start address not loaded");

endmodule

### sv/c8ex_gpr.sv
// V0..VF register file: storage, valid bits and operand capture with write forwarding.
module c8ex_gpr
    import c8ex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_en,
    input  logic [3:0] rd_x,
    input  logic [3:0] rd_y,
    input  logic       wb_en,
    input  c8ex_wb_t   wb,
    output logic [7:0] vx,
    output logic [7:0] vy,
    output logic [7:0] v0
);

    // V0..VE live in the array; VF is a flop of its own since it takes two writes
    logic [7:0]  gpr_mem [16];
    logic [15:0] vld_reg;
    logic [7:0]  vf_reg;
    logic [7:0]  vf_next;
    logic [7:0]  v0_reg;
    logic [7:0]  vx_reg;
    logic [7:0]  vy_reg;
    logic        mem_we;

    assign mem_we = wb_en && wb.gpr_we && (wb.gpr_addr != FLAG_IDX);

    always_comb
    begin
        vf_next = vf_reg;
        if (wb_en && wb.gpr_we && (wb.gpr_addr == FLAG_IDX))
            vf_next = wb.gpr_data;
        if (wb_en && wb.flag_we)
            vf_next = {7'd0, wb.flag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vf_reg  <= '0;
            v0_reg  <= '0;
        end
        else
        begin
            vf_reg <= vf_next;
            if (mem_we)
                vld_reg[wb.gpr_addr] <= 1'b1;
            if (mem_we && (wb.gpr_addr == 4'd0))
                v0_reg <= wb.gpr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            gpr_mem[wb.gpr_addr] <= wb.gpr_data;
    end

    // operand read, sees the write of the item executing at the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (rd_x == FLAG_IDX)
                vx_reg <= vf_next;
            else if (mem_we && (wb.gpr_addr == rd_x))
                vx_reg <= wb.gpr_data;
            else if (vld_reg[rd_x])
                vx_reg <= gpr_mem[rd_x];
            else
                vx_reg <= '0;

            if (rd_y == FLAG_IDX)
                vy_reg <= vf_next;
            else if (mem_we && (wb.gpr_addr == rd_y))
                vy_reg <= wb.gpr_data;
            else if (vld_reg[rd_y])
                vy_reg <= gpr_mem[rd_y];
            else
                vy_reg <= '0;
        end
    end

    assign vx = vx_reg;
    assign vy = vy_reg;
    assign v0 = v0_reg;

endmodule

### sv/c8ex_exec.sv
// Instruction decode and execute: next PC, I, timers, status and register write-back.
module c8ex_exec
    import c8ex_pkg::*;
(
    input  c8ex_in_t     item,
    input  logic [7:0]   vx,
    input  logic [7:0]   vy,
    input  logic [7:0]   v0,
    input  logic [11:0]  pc,
    input  logic [15:0]  index_cur,
    input  logic [7:0]   delay_cur,
    input  logic [7:0]   sound_cur,
    output logic [11:0]  pc_new,
    output logic [15:0]  index_new,
    output logic [7:0]   delay_new,
    output logic [7:0]   sound_new,
    output c8ex_status_t status,
    output c8ex_wb_t     wb
);

    logic [3:0]  op;
    logic [3:0]  x;
    logic [3:0]  n;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [11:0] pc_inc;
    logic        skip;
    logic        key_hit;
    logic [8:0]  sum9;

    assign op      = item.instruction[15:12];
    assign x       = item.instruction[11:8];
    assign n       = item.instruction[3:0];
    assign nn      = item.instruction[7:0];
    assign nnn     = item.instruction[11:0];
    assign pc_inc  = pc + PC_STEP;
    assign key_hit = item.key_mask[vx[3:0]];
    assign sum9    = {1'b0, vx} + {1'b0, vy};

    always_comb
    begin
        skip        = 1'b0;
        status      = ST_OK;
        pc_new      = pc_inc;
        index_new   = index_cur;
        delay_new   = delay_cur;
        sound_new   = sound_cur;
        wb.gpr_we   = 1'b0;
        wb.gpr_addr = x;
        wb.gpr_data = '0;
        wb.flag_we  = 1'b0;
        wb.flag     = 1'b0;

        unique case (op) inside
            OP_SYS, OP_CALL, OP_DRW: status = ST_UNIMPL;
            OP_JP:    pc_new = nnn;
            OP_SE_I:  skip = (vx == nn);
            OP_SNE_I: skip = (vx != nn);
            OP_SE_R:  skip = (vx == vy);
            OP_SNE_R: skip = (vx != vy);
            OP_LD_I:
            begin
                wb.gpr_we   = 1'b1;
                wb.gpr_data = nn;
            end
            OP_ADD_I:
            begin
                wb.gpr_we   = 1'b1;
                wb.gpr_data = vx + nn;
            end
            OP_ALU:
            begin
                wb.gpr_we = 1'b1;
                unique case (n)
                    ALU_LD:  wb.gpr_data = vy;
                    ALU_OR:  wb.gpr_data = vx | vy;
                    ALU_AND: wb.gpr_data = vx & vy;
                    ALU_XOR: wb.gpr_data = vx ^ vy;
                    ALU_ADD:
                    begin
                        wb.gpr_data = sum9[7:0];
                        wb.flag_we  = 1'b1;
                        wb.flag     = sum9[8];
                    end
                    ALU_SUB:
                    begin
                        wb.gpr_data = vx - vy;
                        wb.flag_we  = 1'b1;
                        wb.flag     = (vx >= vy);
                    end
                    ALU_SHR:
                    begin
                        wb.gpr_data = {1'b0, vy[7:1]};
                        wb.flag_we  = 1'b1;
                        wb.flag     = vy[0];
                    end
                    ALU_SBN:
                    begin
                        wb.gpr_data = vy - vx;
                        wb.flag_we  = 1'b1;
                        wb.flag     = (vy >= vx);
                    end
                    ALU_SHL:
                    begin
                        wb.gpr_data = {vy[6:0], 1'b0};
                        wb.flag_we  = 1'b1;
                        wb.flag     = vy[7];
                    end
                    default:
                    begin
                        wb.gpr_we = 1'b0;
                        status    = ST_UNKNOWN;
                    end
                endcase
            end
            OP_LD_IX: index_new = {4'd0, nnn};
            OP_JP_V0: pc_new = {4'd0, v0} + nnn;
            OP_RND:
            begin
                wb.gpr_we   = 1'b1;
                wb.gpr_data = item.random_byte & nn;
            end
            OP_KEY:
            begin
                if (nn == KEY_SKP)
                    skip = key_hit;
                else if (nn == KEY_SKNP)
                    skip = !key_hit;
                else
                    status = ST_UNKNOWN;
            end
            OP_MISC:
            begin
                unique case (nn) inside
                    FX_LD_DT:
                    begin
                        wb.gpr_we   = 1'b1;
                        wb.gpr_data = delay_cur;
                    end
                    FX_SET_DT: delay_new = vx;
                    FX_SET_ST: sound_new = vx;
                    FX_ADD_I:  index_new = index_cur + {8'd0, vx};
                    FX_WAITK, FX_FONT, FX_BCD, FX_STORE, FX_LOAD: status = ST_UNIMPL;
                    default:   status = ST_UNKNOWN;
                endcase
            end
            default: status = ST_UNKNOWN;
        endcase

        if (skip)
            pc_new = pc_inc + PC_STEP;
    end

endmodule
